// ===== hdl/cdr_pkg.sv =====
// Shared types, constants and codes for the circular deque ring buffer.
package cdr_pkg;

  localparam int DEPTH     = 1024;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CAP_W     = 11;
  localparam int CAP_RESET = (1024 > DEPTH) ? DEPTH : 1024;
  localparam int Q_DEPTH   = 2;
  localparam int Q_AW      = $clog2(Q_DEPTH);
  localparam int Q_CW      = $clog2(Q_DEPTH + 1);
  localparam int ADDR_W    = 3;

  localparam logic [ADDR_W-1:0] REG_CAPACITY = 3'd0;

  localparam logic [2:0] OPC_NONE         = 3'd0;
  localparam logic [2:0] OPC_INSERT_FRONT = 3'd1;
  localparam logic [2:0] OPC_INSERT_REAR  = 3'd2;
  localparam logic [2:0] OPC_DELETE_FRONT = 3'd3;
  localparam logic [2:0] OPC_DELETE_REAR  = 3'd4;

  typedef enum logic [2:0] {
    K_NONE,
    K_PUSH_FRONT,
    K_PUSH_REAR,
    K_POP_FRONT,
    K_POP_REAR
  } op_kind_t;

  typedef enum logic [1:0] {
    ST_EXEC,
    ST_READ,
    ST_LOAD
  } back_state_t;

  typedef struct packed {
    logic [2:0]          operation;
    logic signed [31:0]  value;
  } in_item_t;

  typedef struct packed {
    logic                ok;
    logic signed [31:0]  front_value;
    logic signed [31:0]  rear_value;
    logic                is_empty;
    logic                is_full;
    logic [CAP_W-1:0]    count;
  } out_item_t;

  typedef struct packed {
    op_kind_t            kind;
    logic signed [31:0]  value;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0]    count;
    logic                busy;
  } bk_stat_t;

endpackage

// ===== hdl/cdr_front.sv =====
// Front end: takes input requests and classifies the operation code.
module cdr_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  cdr_pkg::in_item_t in_data,
  output logic              push_valid,
  input  logic              push_ready,
  output cdr_pkg::cmd_t     push_cmd
);

  always_comb begin
    push_cmd.value = in_data.value;
    case (in_data.operation)
      cdr_pkg::OPC_INSERT_FRONT: push_cmd.kind = cdr_pkg::K_PUSH_FRONT;
      cdr_pkg::OPC_INSERT_REAR:  push_cmd.kind = cdr_pkg::K_PUSH_REAR;
      cdr_pkg::OPC_DELETE_FRONT: push_cmd.kind = cdr_pkg::K_POP_FRONT;
      cdr_pkg::OPC_DELETE_REAR:  push_cmd.kind = cdr_pkg::K_POP_REAR;
      default:                   push_cmd.kind = cdr_pkg::K_NONE;
    endcase
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

// ===== hdl/cdr_queue.sv =====
// Short command queue between the front end and the back end.
module cdr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  cdr_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output cdr_pkg::cmd_t pop_cmd
);

  cdr_pkg::cmd_t                 slot_r [cdr_pkg::Q_DEPTH];
  logic [cdr_pkg::Q_AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [cdr_pkg::Q_AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [cdr_pkg::Q_CW-1:0]      cnt_r, cnt_nxt;
  logic                          do_push, do_pop;

  assign push_ready = (cnt_r != cdr_pkg::Q_CW'(cdr_pkg::Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == cdr_pkg::Q_AW'(cdr_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == cdr_pkg::Q_AW'(cdr_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hdl/cdr_back.sv =====
// Back end: ring pointers, element store, sequencer and result register.
module cdr_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clear,
  input  logic [cdr_pkg::CNT_W-1:0]   cap,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  cdr_pkg::cmd_t               cmd,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cdr_pkg::out_item_t          out_data,
  output cdr_pkg::bk_stat_t           stat
);

  localparam int IW = cdr_pkg::IDX_W;
  localparam int CW = cdr_pkg::CNT_W;

  function automatic logic [IW-1:0] step_back(logic [IW-1:0] idx, logic [CW-1:0] c);
    logic [CW-1:0] last;
    last = c - 1'b1;
    if (idx == '0 || CW'(idx) >= c) begin
      return IW'(last);
    end
    return idx - 1'b1;
  endfunction

  function automatic logic [IW-1:0] step_fwd(logic [IW-1:0] idx, logic [CW-1:0] c);
    logic [CW:0] inc;
    inc = (CW + 1)'(idx) + 1'b1;
    if (inc >= (CW + 1)'(c)) begin
      return '0;
    end
    return idx + 1'b1;
  endfunction

  cdr_pkg::back_state_t state_r, state_nxt;

  logic [IW-1:0]       front_idx_r, front_idx_nxt;
  logic [IW-1:0]       rear_idx_r, rear_idx_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                ok_r, ok_nxt;
  logic signed [31:0]  rd_front_r, rd_rear_r;
  logic                out_valid_r, out_valid_nxt;
  cdr_pkg::out_item_t  out_data_r;

  logic [31:0]         mem [cdr_pkg::DEPTH];

  logic                pop, mem_we, rd_en, load;
  logic [IW-1:0]       wr_addr;
  logic                full_now, empty_now, empty_post;

  assign full_now  = (count_r >= cap);
  assign empty_now = (count_r == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cdr_pkg::ST_EXEC: if (cmd_valid) state_nxt = cdr_pkg::ST_READ;
      cdr_pkg::ST_READ: state_nxt = cdr_pkg::ST_LOAD;
      cdr_pkg::ST_LOAD: if (!out_valid_r || out_ready) state_nxt = cdr_pkg::ST_EXEC;
      default:          state_nxt = cdr_pkg::ST_EXEC;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop   = 1'b0;
    rd_en = 1'b0;
    load  = 1'b0;
    case (state_r)
      cdr_pkg::ST_EXEC: pop   = cmd_valid;
      cdr_pkg::ST_READ: rd_en = 1'b1;
      cdr_pkg::ST_LOAD: load  = !out_valid_r || out_ready;
      default:          pop   = 1'b0;
    endcase
  end

  assign cmd_ready = pop;

  // pointer and count update
  always_comb begin
    front_idx_nxt = front_idx_r;
    rear_idx_nxt  = rear_idx_r;
    count_nxt     = count_r;
    ok_nxt        = ok_r;
    mem_we        = 1'b0;
    wr_addr       = front_idx_r;
    if (pop) begin
      ok_nxt = 1'b1;
      case (cmd.kind)
        cdr_pkg::K_PUSH_FRONT: begin
          if (full_now) begin
            ok_nxt = 1'b0;
          end else begin
            front_idx_nxt = step_back(front_idx_r, cap);
            wr_addr       = front_idx_nxt;
            mem_we        = 1'b1;
            count_nxt     = count_r + 1'b1;
          end
        end
        cdr_pkg::K_PUSH_REAR: begin
          if (full_now) begin
            ok_nxt = 1'b0;
          end else begin
            rear_idx_nxt = step_fwd(rear_idx_r, cap);
            wr_addr      = rear_idx_nxt;
            mem_we       = 1'b1;
            count_nxt    = count_r + 1'b1;
          end
        end
        cdr_pkg::K_POP_FRONT: begin
          if (empty_now) begin
            ok_nxt = 1'b0;
          end else begin
            front_idx_nxt = step_fwd(front_idx_r, cap);
            count_nxt     = count_r - 1'b1;
          end
        end
        cdr_pkg::K_POP_REAR: begin
          if (empty_now) begin
            ok_nxt = 1'b0;
          end else begin
            rear_idx_nxt = step_back(rear_idx_r, cap);
            count_nxt    = count_r - 1'b1;
          end
        end
        default: ok_nxt = 1'b1;
      endcase
    end
  end

  assign empty_post    = (count_r == '0);
  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cdr_pkg::ST_EXEC;
      front_idx_r <= '0;
      rear_idx_r  <= IW'(cdr_pkg::CAP_RESET - 1);
      count_r     <= '0;
      ok_r        <= 1'b1;
      out_valid_r <= 1'b0;
    end else if (clear) begin
      state_r     <= state_nxt;
      front_idx_r <= '0;
      rear_idx_r  <= IW'(cap - 1'b1);
      count_r     <= '0;
      ok_r        <= ok_nxt;
      out_valid_r <= out_valid_nxt;
    end else begin
      state_r     <= state_nxt;
      front_idx_r <= front_idx_nxt;
      rear_idx_r  <= rear_idx_nxt;
      count_r     <= count_nxt;
      ok_r        <= ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= cmd.value;
    end
    if (rd_en) begin
      rd_front_r <= mem[front_idx_r];
      rd_rear_r  <= mem[rear_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.ok          <= ok_r;
      out_data_r.front_value <= empty_post ? -32'sd1 : rd_front_r;
      out_data_r.rear_value  <= empty_post ? -32'sd1 : rd_rear_r;
      out_data_r.is_empty    <= empty_post;
      out_data_r.is_full     <= (count_r >= cap);
      out_data_r.count       <= cdr_pkg::CAP_W'(count_r);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign stat.count = count_r;
  assign stat.busy  = (state_r != cdr_pkg::ST_EXEC);

endmodule

// ===== hdl/circular_deque_ring_top.sv =====
// Top level of the circular deque ring buffer: config port and wiring.
//
//  channel  signals                           direction
//  in       in_valid, in_ready, in_data       request into the block
//  out      out_valid, out_ready, out_data    result out of the block
//  cfg      psel, penable, pwrite, paddr,     register access, capacity at 0x0
//           pwdata, prdata, pready
//
// An item passes through the back-end sequencer in order (update and store write,
// store read, result load); no new item enters before the last one is loaded.
// Reset (rst_n low, synchronous) empties the deque, capacity returns to 1024.
// A two-entry queue keeps accepting requests, until it is full, while the back
// end works or the result register waits on out_ready.
module circular_deque_ring_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cdr_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cdr_pkg::out_item_t            out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cdr_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int CW = cdr_pkg::CNT_W;

  logic [CW-1:0]             cap_r, cap_nxt;
  logic                      cap_wr;
  logic [cdr_pkg::CAP_W-1:0] wr_val;
  logic [CW-1:0]             cap_nxt_sel;

  logic                      push_valid, push_ready, pop_valid, pop_ready;
  cdr_pkg::cmd_t             push_cmd, pop_cmd;
  cdr_pkg::bk_stat_t         stat;

  assign pready = 1'b1;
  assign cap_wr = psel && penable && pwrite && pready &&
                  (paddr[cdr_pkg::ADDR_W-1:2] == cdr_pkg::REG_CAPACITY[cdr_pkg::ADDR_W-1:2]);
  assign wr_val = pwdata[cdr_pkg::CAP_W-1:0];

  always_comb begin
    if (wr_val == '0) begin
      cap_nxt = CW'(1);
    end else if (32'(wr_val) > 32'(cdr_pkg::DEPTH)) begin
      cap_nxt = CW'(cdr_pkg::DEPTH);
    end else begin
      cap_nxt = CW'(wr_val);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CW'(cdr_pkg::CAP_RESET);
    end else if (cap_wr) begin
      cap_r <= cap_nxt;
    end
  end

  assign prdata = 32'(cap_r);

  // the back end sees the new capacity in the same cycle it empties the deque
  assign cap_nxt_sel = cap_wr ? cap_nxt : cap_r;

  cdr_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  cdr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  cdr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (cap_wr),
    .cap       (cap_nxt_sel),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .stat      (stat)
  );

  a_count_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.busy |-> (stat.count <= cap_r))
    else $error("element count above capacity");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_empty == (out_data.count == '0)))
    else $error("empty flag disagrees with count");

  a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.is_empty) |->
      (out_data.front_value == -32'sd1 && out_data.rear_value == -32'sd1))
    else $error("empty deque reports an element");

endmodule
